// ===== rtl/core/vrs_pkg.sv =====
// ----------------------------------------------------------------------------
// Vorticity RHS stencil package
// Widths, register indexes and lane types shared by the stencil datapath.
// ----------------------------------------------------------------------------
package vrs_pkg;

  localparam int DATA_W    = 32;
  localparam int COEF_W    = 48;
  localparam int VISC_W    = 32;
  localparam int CFG_IDX_W = 8;
  localparam int NUM_LANES = 3;

  localparam int DIFF_W = DATA_W + 1;
  localparam int LAP_W  = DATA_W + 3;
  localparam int PROD_W = LAP_W + VISC_W + 1;
  localparam int AHI_W  = PROD_W - 32;
  localparam int HL_W   = AHI_W + 33;
  localparam int HH_W   = AHI_W + COEF_W - 32 + 1;
  localparam int HI_W   = HH_W + 33;
  localparam int LO_W   = 32 + COEF_W + 1;
  localparam int FULL_W = 120;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HALF_INV_DX         = 8'd0,
    REG_HALF_INV_DY         = 8'd1,
    REG_INV_DX_SQUARED      = 8'd2,
    REG_KINEMATIC_VISCOSITY = 8'd3
  } cfg_reg_t;

  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [FULL_W-1:0] full_t;

endpackage

// ===== rtl/core/vorticity_rhs_stencil.sv =====
// ----------------------------------------------------------------------------
// Vorticity RHS stencil
// Pipelined right-hand side of the 2D vorticity transport equation.
// ----------------------------------------------------------------------------
// A cell is accepted on a rising edge where start is high and busy is low;
// busy is always low, so a new cell may be issued every clock cycle.
// Each cell carries its vorticity, four neighbours and two velocities.
// The result appears on rate and clipped with done high for exactly one
// cycle, in issue order.
// Throughput is one cell per cycle; each cell passes through nine register
// stages: differences, first product, four partial products against the
// 48-bit coefficients, two partial-sum stages, advection sum, scaling,
// final add and saturation.
// The receiver cannot stall, so results are never held back.
// Configuration is written through cfg_valid/cfg_index/cfg_data; cfg_ready
// is always high and a transaction to an unknown index is ignored.
// Registers should only be written while no cell is in flight.
// Synchronous reset clears the pipeline valid bits and restores the
// register defaults; cells in flight at reset are dropped.
// ----------------------------------------------------------------------------
module vorticity_rhs_stencil #(
  parameter int FRAC_BITS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  output logic                                 busy,
  input  logic signed [vrs_pkg::DATA_W-1:0]    center,
  input  logic signed [vrs_pkg::DATA_W-1:0]    east,
  input  logic signed [vrs_pkg::DATA_W-1:0]    west,
  input  logic signed [vrs_pkg::DATA_W-1:0]    north,
  input  logic signed [vrs_pkg::DATA_W-1:0]    south,
  input  logic signed [vrs_pkg::DATA_W-1:0]    vel_x,
  input  logic signed [vrs_pkg::DATA_W-1:0]    vel_y,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [vrs_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [vrs_pkg::COEF_W-1:0]           cfg_data,
  output logic                                 done,
  output logic signed [vrs_pkg::DATA_W-1:0]    rate,
  output logic                                 clipped
);

  localparam int ADV_SHIFT  = 2 * FRAC_BITS;
  localparam int VISC_SHIFT = FRAC_BITS + 32;
  localparam int NSTAGE     = 9;
  localparam int SAT_LO     = vrs_pkg::DATA_W - 1;

  logic [vrs_pkg::COEF_W-1:0] half_inv_dx;
  logic [vrs_pkg::COEF_W-1:0] half_inv_dy;
  logic [vrs_pkg::COEF_W-1:0] inv_dx_squared;
  logic [vrs_pkg::VISC_W-1:0] kinematic_viscosity;

  logic [NSTAGE:1] valid;

  logic signed [vrs_pkg::DIFF_W-1:0] ddx;
  logic signed [vrs_pkg::DIFF_W-1:0] ddy;
  logic signed [vrs_pkg::LAP_W-1:0]  lap;
  logic signed [vrs_pkg::DATA_W-1:0] ux;
  logic signed [vrs_pkg::DATA_W-1:0] vy;

  vrs_pkg::prod_t             prod   [vrs_pkg::NUM_LANES];
  logic [vrs_pkg::COEF_W-1:0] coef   [vrs_pkg::NUM_LANES];
  logic [63:0]                pp_ll  [vrs_pkg::NUM_LANES];
  logic [vrs_pkg::COEF_W-1:0] pp_lh  [vrs_pkg::NUM_LANES];
  logic signed [vrs_pkg::HL_W-1:0] pp_hl [vrs_pkg::NUM_LANES];
  logic signed [vrs_pkg::HH_W-1:0] pp_hh [vrs_pkg::NUM_LANES];
  logic [vrs_pkg::LO_W-1:0]        lo_sum [vrs_pkg::NUM_LANES];
  logic signed [vrs_pkg::HI_W-1:0] hi_sum [vrs_pkg::NUM_LANES];
  vrs_pkg::full_t             full   [vrs_pkg::NUM_LANES];

  vrs_pkg::full_t adv_sum;
  vrs_pkg::full_t visc_full;
  vrs_pkg::full_t adv_scaled;
  vrs_pkg::full_t visc_scaled;
  vrs_pkg::full_t total;

  logic in_range;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      half_inv_dx         <= 48'd8388608;
      half_inv_dy         <= 48'd8388608;
      inv_dx_squared      <= 48'd4294967296;
      kinematic_viscosity <= 32'd429497;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        vrs_pkg::REG_HALF_INV_DX:         half_inv_dx <= cfg_data;
        vrs_pkg::REG_HALF_INV_DY:         half_inv_dy <= cfg_data;
        vrs_pkg::REG_INV_DX_SQUARED:      inv_dx_squared <= cfg_data;
        vrs_pkg::REG_KINEMATIC_VISCOSITY:
          kinematic_viscosity <= cfg_data[vrs_pkg::VISC_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      valid <= {valid[NSTAGE-1:1], start && !busy};
    end
  end

  always_ff @(posedge clk) begin
    ddx <= vrs_pkg::DIFF_W'(east) - vrs_pkg::DIFF_W'(west);
    ddy <= vrs_pkg::DIFF_W'(north) - vrs_pkg::DIFF_W'(south);
    lap <= vrs_pkg::LAP_W'(east) + vrs_pkg::LAP_W'(west) + vrs_pkg::LAP_W'(north)
         + vrs_pkg::LAP_W'(south) - (vrs_pkg::LAP_W'(center) <<< 2);
    ux  <= vel_x;
    vy  <= vel_y;
  end

  always_ff @(posedge clk) begin
    prod[0] <= ux * ddx;
    prod[1] <= vy * ddy;
    prod[2] <= lap * $signed({1'b0, kinematic_viscosity});
  end

  assign coef[0] = half_inv_dx;
  assign coef[1] = half_inv_dy;
  assign coef[2] = inv_dx_squared;

  for (genvar i = 0; i < vrs_pkg::NUM_LANES; i++) begin : g_lane
    always_ff @(posedge clk) begin
      pp_ll[i] <= prod[i][31:0] * coef[i][31:0];
      pp_lh[i] <= prod[i][31:0] * coef[i][vrs_pkg::COEF_W-1:32];
      pp_hl[i] <= $signed(prod[i][vrs_pkg::PROD_W-1:32])
                * $signed({1'b0, coef[i][31:0]});
      pp_hh[i] <= $signed(prod[i][vrs_pkg::PROD_W-1:32])
                * $signed({1'b0, coef[i][vrs_pkg::COEF_W-1:32]});
    end

    always_ff @(posedge clk) begin
      lo_sum[i] <= vrs_pkg::LO_W'(pp_ll[i]) + vrs_pkg::LO_W'({pp_lh[i], 32'b0});
      hi_sum[i] <= vrs_pkg::HI_W'(pp_hl[i])
                 + vrs_pkg::HI_W'($signed({pp_hh[i], 32'b0}));
    end

    always_ff @(posedge clk) begin
      full[i] <= vrs_pkg::FULL_W'($signed({hi_sum[i], 32'b0}))
               + vrs_pkg::FULL_W'($signed({1'b0, lo_sum[i]}));
    end
  end

  always_ff @(posedge clk) begin
    adv_sum     <= full[0] + full[1];
    visc_full   <= full[2];
    adv_scaled  <= (-adv_sum) >>> ADV_SHIFT;
    visc_scaled <= visc_full >>> VISC_SHIFT;
    total       <= adv_scaled + visc_scaled;
  end

  assign in_range = (&total[vrs_pkg::FULL_W-1:SAT_LO]) || !(|total[vrs_pkg::FULL_W-1:SAT_LO]);

  always_ff @(posedge clk) begin
    if (in_range) begin
      rate    <= total[vrs_pkg::DATA_W-1:0];
      clipped <= 1'b0;
    end else begin
      rate    <= total[vrs_pkg::FULL_W-1] ? {1'b1, {(vrs_pkg::DATA_W-1){1'b0}}}
                                         : {1'b0, {(vrs_pkg::DATA_W-1){1'b1}}};
      clipped <= 1'b1;
    end
  end

  assign done = valid[NSTAGE];

endmodule

// ===== dv/tb_vorticity_rhs_stencil.sv =====
// ----------------------------------------------------------------------------
// Vorticity RHS stencil testbench
// Streams stencil cells through the block under several coefficient settings,
// predicts each rate and clip flag with exact wide arithmetic and checks every
// result in order against the prediction.
// ----------------------------------------------------------------------------
module tb_vorticity_rhs_stencil;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC_BITS = 16;
  localparam int QUIET_LIMIT = 2000;
  localparam int TAIL_CYCLES = 20;
  localparam int RANDOM_PER_PHASE = 277;
  localparam int NUM_PHASES = 7;
  localparam logic [vrs_pkg::CFG_IDX_W-1:0] REG_UNMAPPED = 8'hA5;
  localparam logic signed [vrs_pkg::DATA_W-1:0] W_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [vrs_pkg::DATA_W-1:0] W_MIN = 32'sh8000_0000;
  localparam logic signed [127:0] RATE_MAX = 128'sd2147483647;
  localparam logic signed [127:0] RATE_MIN = -128'sd2147483648;

  typedef struct packed {
    logic signed [vrs_pkg::DATA_W-1:0] center;
    logic signed [vrs_pkg::DATA_W-1:0] east;
    logic signed [vrs_pkg::DATA_W-1:0] west;
    logic signed [vrs_pkg::DATA_W-1:0] north;
    logic signed [vrs_pkg::DATA_W-1:0] south;
    logic signed [vrs_pkg::DATA_W-1:0] vel_x;
    logic signed [vrs_pkg::DATA_W-1:0] vel_y;
  } cell_t;

  typedef struct packed {
    logic signed [vrs_pkg::DATA_W-1:0] rate;
    logic                              clipped;
  } rate_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  cell_t on_ports = '0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [vrs_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [vrs_pkg::COEF_W-1:0] cfg_data = '0;
  logic done;
  logic signed [vrs_pkg::DATA_W-1:0] rate;
  logic clipped;

  logic [vrs_pkg::COEF_W-1:0] coef_dx = 48'd8388608;
  logic [vrs_pkg::COEF_W-1:0] coef_dy = 48'd8388608;
  logic [vrs_pkg::COEF_W-1:0] coef_lap = 48'd4294967296;
  logic [vrs_pkg::VISC_W-1:0] visc_frac = 32'd429497;

  cell_t pending_cells[$];
  rate_t expected_rates[$];
  cell_t next_cell;
  rate_t oldest_rate;
  int unsigned sender_idle_pct = 0;
  int unsigned quiet_cycles = 0;
  int errors = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  vorticity_rhs_stencil #(
    .FRAC_BITS(FRAC_BITS)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .center(on_ports.center),
    .east(on_ports.east),
    .west(on_ports.west),
    .north(on_ports.north),
    .south(on_ports.south),
    .vel_x(on_ports.vel_x),
    .vel_y(on_ports.vel_y),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .done(done),
    .rate(rate),
    .clipped(clipped)
  );

  function automatic rate_t predict_rate(cell_t cur);
    logic signed [127:0] c_w, e_w, w_w, n_w, s_w, ux_w, vy_w;
    logic signed [127:0] kx_w, ky_w, kl_w, nu_w;
    logic signed [127:0] dx_w, dy_w, lap_w, adv_w, visc_w, sum_w;
    rate_t res;
    c_w = cur.center;
    e_w = cur.east;
    w_w = cur.west;
    n_w = cur.north;
    s_w = cur.south;
    ux_w = cur.vel_x;
    vy_w = cur.vel_y;
    kx_w = {80'd0, coef_dx};
    ky_w = {80'd0, coef_dy};
    kl_w = {80'd0, coef_lap};
    nu_w = {96'd0, visc_frac};
    dx_w = e_w - w_w;
    dy_w = n_w - s_w;
    lap_w = e_w + w_w + n_w + s_w - 4 * c_w;
    adv_w = -(ux_w * dx_w * kx_w + vy_w * dy_w * ky_w);
    adv_w = adv_w >>> (2 * FRAC_BITS);
    visc_w = (lap_w * nu_w * kl_w) >>> (FRAC_BITS + 32);
    sum_w = adv_w + visc_w;
    if (sum_w > RATE_MAX) begin
      res.rate = W_MAX;
      res.clipped = 1'b1;
    end else if (sum_w < RATE_MIN) begin
      res.rate = W_MIN;
      res.clipped = 1'b1;
    end else begin
      res.rate = sum_w[vrs_pkg::DATA_W-1:0];
      res.clipped = 1'b0;
    end
    return res;
  endfunction

  function automatic logic signed [vrs_pkg::DATA_W-1:0] rand_word();
    int unsigned pick;
    logic [vrs_pkg::DATA_W-1:0] raw;
    pick = $urandom_range(9);
    raw = $urandom;
    if (pick < 4) begin
      return raw;
    end else if (pick < 8) begin
      return $signed(raw) >>> $urandom_range(30, 8);
    end
    case (raw[2:0])
      3'd0: return W_MAX;
      3'd1: return W_MIN;
      3'd2: return '0;
      3'd3: return -32'sd1;
      3'd4: return 32'sd1;
      default: return raw;
    endcase
  endfunction

  function automatic logic signed [vrs_pkg::DATA_W-1:0] small_word(int unsigned min_shift);
    return $signed(vrs_pkg::DATA_W'($urandom)) >>> $urandom_range(31, min_shift);
  endfunction

  function automatic cell_t random_cell();
    cell_t cur;
    logic signed [vrs_pkg::DATA_W-1:0] base;
    base = rand_word();
    case ($urandom_range(2))
      0: begin
        cur = '{rand_word(), rand_word(), rand_word(), rand_word(), rand_word(),
                rand_word(), rand_word()};
      end
      1: begin
        cur = '{base, base + small_word(18), base + small_word(18),
                base + small_word(18), base + small_word(18), rand_word(), rand_word()};
      end
      default: begin
        cur = '{small_word(12), small_word(12), small_word(12), small_word(12),
                small_word(12), small_word(12), small_word(12)};
      end
    endcase
    return cur;
  endfunction

  function automatic logic [vrs_pkg::COEF_W-1:0] rand_coef();
    logic [vrs_pkg::COEF_W-1:0] raw;
    raw = {16'($urandom), 32'($urandom)};
    return raw >> $urandom_range(40);
  endfunction

  task automatic queue_cell(input logic signed [vrs_pkg::DATA_W-1:0] c, e, w, n, s, ux, vy);
    pending_cells.push_back(cell_t'{c, e, w, n, s, ux, vy});
  endtask

  task automatic write_reg(input logic [vrs_pkg::CFG_IDX_W-1:0] idx,
                           input logic [vrs_pkg::COEF_W-1:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      vrs_pkg::REG_HALF_INV_DX: coef_dx = value;
      vrs_pkg::REG_HALF_INV_DY: coef_dy = value;
      vrs_pkg::REG_INV_DX_SQUARED: coef_lap = value;
      vrs_pkg::REG_KINEMATIC_VISCOSITY: visc_frac = value[vrs_pkg::VISC_W-1:0];
      default: ;
    endcase
  endtask

  task automatic wait_drained();
    while (pending_cells.size() != 0 || start || expected_rates.size() != 0) begin
      @(negedge clk);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        expected_rates.push_back(predict_rate(on_ports));
      end
      if (!start || !busy) begin
        if (pending_cells.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
          next_cell = pending_cells.pop_front();
          on_ports <= next_cell;
          start <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && done) begin
      if (expected_rates.size() == 0) begin
        $display("%0t: unexpected result, expected none actual rate %h clipped %b",
                 $time, rate, clipped);
        errors++;
      end else begin
        oldest_rate = expected_rates.pop_front();
        if (rate !== oldest_rate.rate) begin
          $display("%0t: rate mismatch, expected %h actual %h",
                   $time, oldest_rate.rate, rate);
          errors++;
        end
        if (clipped !== oldest_rate.clipped) begin
          $display("%0t: clipped mismatch, expected %b actual %b",
                   $time, oldest_rate.clipped, clipped);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, QUIET_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    queue_cell(0, 0, 0, 0, 0, 0, 0);
    queue_cell(W_MAX, W_MAX, W_MAX, W_MAX, W_MAX, W_MAX, W_MAX);
    queue_cell(W_MIN, W_MIN, W_MIN, W_MIN, W_MIN, W_MIN, W_MIN);
    queue_cell(W_MAX, W_MIN, W_MIN, W_MIN, W_MIN, 0, 0);
    queue_cell(W_MIN, W_MAX, W_MAX, W_MAX, W_MAX, 0, 0);
    queue_cell(0, W_MAX, W_MIN, W_MAX, W_MIN, W_MAX, W_MAX);
    queue_cell(0, W_MIN, W_MAX, W_MAX, W_MIN, W_MAX, W_MIN);
    queue_cell(0, W_MAX, W_MIN, W_MIN, W_MAX, W_MIN, W_MIN);
    queue_cell(W_MIN, W_MIN, W_MAX, W_MIN, W_MAX, W_MIN, W_MAX);
    queue_cell(0, 1, 0, 0, 0, 1, 0);
    queue_cell(0, 0, 1, 0, 0, 1, 0);
    queue_cell(0, 0, 0, 1, 0, 0, -1);
    queue_cell(1, 0, 0, 0, 0, 0, 0);
    queue_cell(-1, 0, 0, 0, 0, 0, 0);
    queue_cell(32'sh10000, 32'sh18000, 32'sh8000, 32'sh20000, 0, 32'sh10000, -32'sh10000);
    queue_cell(32'sh7FFF0000, 32'sh7FFF8000, 32'sh7FFE8000, 32'sh7FFF0001, 32'sh7FFEFFFF,
               32'sh40000, 32'sh40000);

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      sender_idle_pct = (phase < 3) ? 32 : (phase < 5) ? 48 : 0;
      case (phase)
        1: begin
          write_reg(vrs_pkg::REG_HALF_INV_DX, 48'hFFFF_FFFF_FFFF);
          write_reg(vrs_pkg::REG_HALF_INV_DY, 48'hFFFF_FFFF_FFFF);
          write_reg(vrs_pkg::REG_INV_DX_SQUARED, 48'hFFFF_FFFF_FFFF);
          write_reg(vrs_pkg::REG_KINEMATIC_VISCOSITY, 48'hFFFF_FFFF_FFFF);
          write_reg(REG_UNMAPPED, 48'h0);
        end
        2: begin
          write_reg(vrs_pkg::REG_HALF_INV_DX, 48'h0);
          write_reg(vrs_pkg::REG_HALF_INV_DY, 48'h0);
          write_reg(vrs_pkg::REG_INV_DX_SQUARED, 48'h0);
          write_reg(vrs_pkg::REG_KINEMATIC_VISCOSITY, 48'h0);
        end
        3, 4: begin
          write_reg(vrs_pkg::REG_HALF_INV_DX, rand_coef());
          write_reg(vrs_pkg::REG_HALF_INV_DY, rand_coef());
          write_reg(vrs_pkg::REG_INV_DX_SQUARED, rand_coef());
          write_reg(vrs_pkg::REG_KINEMATIC_VISCOSITY, {16'($urandom), 32'($urandom)});
        end
        5: begin
          write_reg(vrs_pkg::REG_HALF_INV_DX, 48'd1);
          write_reg(vrs_pkg::REG_HALF_INV_DY, 48'd1);
          write_reg(vrs_pkg::REG_INV_DX_SQUARED, 48'd1);
          write_reg(vrs_pkg::REG_KINEMATIC_VISCOSITY, 48'hFFFF_FFFF);
        end
        6: begin
          write_reg(vrs_pkg::REG_HALF_INV_DX, 48'd8388608);
          write_reg(vrs_pkg::REG_HALF_INV_DY, 48'd8388608);
          write_reg(vrs_pkg::REG_INV_DX_SQUARED, 48'd4294967296);
          write_reg(vrs_pkg::REG_KINEMATIC_VISCOSITY, 48'd429497);
        end
        default: ;
      endcase
      repeat (RANDOM_PER_PHASE) pending_cells.push_back(random_cell());
      wait_drained();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (expected_rates.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, expected_rates.size());
      errors++;
    end
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
